FILE: design/ccdp_pkg.sv
`default_nettype none
package ccdp_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 48;

    // Product queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Queue status seen by the front (fill level) and the back (empty)
    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage
`default_nettype wire

FILE: design/ccdp_front.sv
`default_nettype none
module ccdp_front #(
    parameter int SAMPLE_WIDTH = ccdp_pkg::SAMPLE_WIDTH_DEF,
    parameter int PW           = 2 * SAMPLE_WIDTH,
    parameter int QW           = 4 * PW + 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x_im,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_im,
    input  wire logic                           i_last_pair,
    input  wire ccdp_pkg::t_q_status            i_q_status,
    output logic                                o_push,
    output logic [QW-1:0]                       o_push_data
);
    import ccdp_pkg::*;

    logic                 accept;
    logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri;
    logic                 r_pv;
    logic [QW-1:0]        r_prod;
    logic [Q_CNT_W:0]     occupancy;

    // Credit check: queued requests plus the one in the product register
    assign occupancy = {1'b0, i_q_status.count} + {{Q_CNT_W{1'b0}}, r_pv};
    assign o_stall   = (occupancy >= (Q_CNT_W+1)'(Q_DEPTH));
    assign accept    = i_valid & ~o_stall;

    // Exact products, x * conj(y)
    assign p_rr = i_x_re * i_y_re;
    assign p_ii = i_x_im * i_y_im;
    assign p_ir = i_x_im * i_y_re;
    assign p_ri = i_x_re * i_y_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= {i_last_pair, p_rr, p_ii, p_ir, p_ri};
        end
    end

    assign o_push      = r_pv;
    assign o_push_data = r_prod;

endmodule
`default_nettype wire

FILE: design/ccdp_fifo.sv
`default_nettype none
module ccdp_fifo #(
    parameter int QW = 4 * 2 * ccdp_pkg::SAMPLE_WIDTH_DEF + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [QW-1:0]      i_push_data,
    input  wire logic               i_pop,
    output logic [QW-1:0]           o_head,
    output ccdp_pkg::t_q_status     o_status
);
    import ccdp_pkg::*;

    logic [QW-1:0]      r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_pop;

    // Front never pushes into a full queue (credit based)
    assign do_pop = i_pop & (r_count != '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule
`default_nettype wire

FILE: design/ccdp_back.sv
`default_nettype none
module ccdp_back #(
    parameter int SAMPLE_WIDTH = ccdp_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = ccdp_pkg::ACC_WIDTH_DEF,
    parameter int PW           = 2 * SAMPLE_WIDTH,
    parameter int QW           = 4 * PW + 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ccdp_pkg::t_q_status   i_q_status,
    input  wire logic [QW-1:0]         i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [ACC_WIDTH-1:0] o_sum_re,
    output logic signed [ACC_WIDTH-1:0] o_sum_im,
    output logic                       o_saturated
);
    import ccdp_pkg::*;

    localparam int SUM_W = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 2;

    logic                        last;
    logic [PW-1:0]               p_rr, p_ii, p_ir, p_ri;
    logic signed [SUM_W-1:0]     s_re, s_im;
    logic [ACC_WIDTH:0]          sat_re, sat_im;
    logic signed [ACC_WIDTH-1:0] r_acc_re, r_acc_im, n_acc_re, n_acc_im;
    logic                        r_clip, n_clip, clip_now;
    logic                        r_ov, n_ov;
    logic signed [ACC_WIDTH-1:0] r_sum_re, r_sum_im;
    logic                        r_sat;
    logic                        out_free;

    // {clip, value}: clamp an exact sum to ACC_WIDTH bits
    function automatic logic [ACC_WIDTH:0] saturate(input logic [SUM_W-1:0] s);
        logic [SUM_W-ACC_WIDTH:0] top;
        logic [ACC_WIDTH:0]       res;
        top = s[SUM_W-1:ACC_WIDTH-1];
        if ((&top) || !(|top)) begin
            res = {1'b0, s[ACC_WIDTH-1:0]};
        end else if (s[SUM_W-1]) begin
            res = {1'b1, 1'b1, {(ACC_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    assign {last, p_rr, p_ii, p_ir, p_ri} = i_head;

    assign s_re = {{(SUM_W-ACC_WIDTH){r_acc_re[ACC_WIDTH-1]}}, r_acc_re}
                + {{(SUM_W-PW){p_rr[PW-1]}}, p_rr}
                + {{(SUM_W-PW){p_ii[PW-1]}}, p_ii};
    assign s_im = {{(SUM_W-ACC_WIDTH){r_acc_im[ACC_WIDTH-1]}}, r_acc_im}
                + {{(SUM_W-PW){p_ir[PW-1]}}, p_ir}
                - {{(SUM_W-PW){p_ri[PW-1]}}, p_ri};

    assign sat_re   = saturate(s_re);
    assign sat_im   = saturate(s_im);
    assign clip_now = r_clip | sat_re[ACC_WIDTH] | sat_im[ACC_WIDTH];

    // A last request needs the result register free
    assign out_free = ~r_ov | ~i_stall;
    assign o_pop    = ~i_q_status.empty & (~last | out_free);

    always_comb begin
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        n_clip   = r_clip;
        n_ov     = r_ov & i_stall;
        if (o_pop) begin
            if (last) begin
                n_acc_re = '0;
                n_acc_im = '0;
                n_clip   = 1'b0;
                n_ov     = 1'b1;
            end else begin
                n_acc_re = sat_re[ACC_WIDTH-1:0];
                n_acc_im = sat_im[ACC_WIDTH-1:0];
                n_clip   = clip_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_clip   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
            r_clip   <= n_clip;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && last) begin
            r_sum_re <= sat_re[ACC_WIDTH-1:0];
            r_sum_im <= sat_im[ACC_WIDTH-1:0];
            r_sat    <= clip_now;
        end
    end

    assign o_valid     = r_ov;
    assign o_sum_re    = r_sum_re;
    assign o_sum_im    = r_sum_im;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

FILE: design/complex_conj_dot_product_unit.sv
// Path: a last request passes the product register and the product queue, then
//   accumulates into the result register.
// Throughput: one request per cycle while results are taken; the single
//   add-and-clamp per accumulator and the 4-entry product queue set that figure.
// Reset: synchronous, active low; clears accumulators, clip flag, queue and valids.
`default_nettype none
module complex_conj_dot_product_unit #(
    parameter int SAMPLE_WIDTH = ccdp_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = ccdp_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request side
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_x_im,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_im,
    input  wire logic                           i_last_pair,
    // result side
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [ACC_WIDTH-1:0]         o_sum_re,
    output logic signed [ACC_WIDTH-1:0]         o_sum_im,
    output logic                                o_saturated
);
    import ccdp_pkg::*;

    // Queue entry: {last, xr*yr, xi*yi, xi*yr, xr*yi}
    localparam int PW = 2 * SAMPLE_WIDTH;
    localparam int QW = 4 * PW + 1;

    logic          push, pop;
    logic [QW-1:0] push_data, head;
    t_q_status     q_status;

    // Front: takes requests while the queue has credit and forms the four
    // exact products in one registered stage.
    ccdp_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PW           (PW),
        .QW           (QW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_x_re      (i_x_re),
        .i_x_im      (i_x_im),
        .i_y_re      (i_y_re),
        .i_y_im      (i_y_im),
        .i_last_pair (i_last_pair),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Short queue so a stalled result side does not block the front at once
    ccdp_fifo #(
        .QW (QW)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // Back: saturating accumulate; a last request loads the result register
    // with the sums and the sticky clip flag, then clears the accumulators.
    ccdp_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .PW           (PW),
        .QW           (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sum_re    (o_sum_re),
        .o_sum_im    (o_sum_im),
        .o_saturated (o_saturated)
    );

endmodule
`default_nettype wire

FILE: verif/dot_product_checker.sv
`default_nettype none
module dot_product_checker #(
    parameter int SW = ccdp_pkg::SAMPLE_WIDTH_DEF,
    parameter int AW = ccdp_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_req_valid,
    input  wire logic                 i_req_stall,
    input  wire logic signed [SW-1:0] i_x_re,
    input  wire logic signed [SW-1:0] i_x_im,
    input  wire logic signed [SW-1:0] i_y_re,
    input  wire logic signed [SW-1:0] i_y_im,
    input  wire logic                 i_last_pair,
    // result channel
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_stall,
    input  wire logic signed [AW-1:0] i_sum_re,
    input  wire logic signed [AW-1:0] i_sum_im,
    input  wire logic                 i_saturated,
    // bookkeeping for the top
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_results,
    output int                        o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ACC_TOP = (longint'(1) <<< (AW - 1)) - 1;
    localparam longint ACC_BOT = -ACC_TOP - 1;

    typedef struct {
        logic signed [AW-1:0] re;
        logic signed [AW-1:0] im;
        logic                 clip;
    } t_dot_sum;

    t_dot_sum             sums_due[$];
    logic signed [AW-1:0] acc_re;
    logic signed [AW-1:0] acc_im;
    logic                 clip_flag;
    int                   fails = 0;
    int                   results = 0;
    int                   clipped = 0;

    assign o_fail_count = fails;
    assign o_pending    = sums_due.size();
    assign o_results    = results;
    assign o_clipped    = clipped;

    // exact three-term sum, then clamp to the accumulator range
    function automatic logic signed [AW-1:0] clamp_accum(input logic signed [AW-1:0] acc,
                                                         input longint p, input longint q);
        longint s;
        s = longint'(acc) + p + q;
        if (s > ACC_TOP) begin
            clip_flag = 1'b1;
            return AW'(ACC_TOP);
        end
        if (s < ACC_BOT) begin
            clip_flag = 1'b1;
            return AW'(ACC_BOT);
        end
        return AW'(s);
    endfunction

    always @(posedge i_clk) begin
        t_dot_sum want;
        longint   xr, xi, yr, yi;
        if (!i_rst_n) begin
            acc_re    = '0;
            acc_im    = '0;
            clip_flag = 1'b0;
        end else begin
            // a result never belongs to a request taken in the same cycle, so pop before push
            if (i_res_valid === 1'b1 && i_res_stall === 1'b0) begin
                if (sums_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result re=%0d im=%0d sat=%0b",
                             $time, i_sum_re, i_sum_im, i_saturated);
                end else begin
                    want = sums_due.pop_front();
                    results++;
                    if (want.clip) clipped++;
                    if (i_sum_re !== want.re) begin
                        fails++;
                        $display("%0t: sum_re expected %0d actual %0d",
                                 $time, want.re, i_sum_re);
                    end
                    if (i_sum_im !== want.im) begin
                        fails++;
                        $display("%0t: sum_im expected %0d actual %0d",
                                 $time, want.im, i_sum_im);
                    end
                    if (i_saturated !== want.clip) begin
                        fails++;
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.clip, i_saturated);
                    end
                end
            end
            if (i_req_valid === 1'b1 && i_req_stall === 1'b0) begin
                xr = longint'(i_x_re);
                xi = longint'(i_x_im);
                yr = longint'(i_y_re);
                yi = longint'(i_y_im);
                acc_re = clamp_accum(acc_re, xr * yr, xi * yi);
                acc_im = clamp_accum(acc_im, xi * yr, -(xr * yi));
                if (i_last_pair) begin
                    want.re   = acc_re;
                    want.im   = acc_im;
                    want.clip = clip_flag;
                    sums_due.push_back(want);
                    acc_re    = '0;
                    acc_im    = '0;
                    clip_flag = 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ccdp_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int AW = ACC_WIDTH_DEF;

    // Random stimulus volume and pacing
    localparam int RANDOM_PAIRS  = 1380;
    localparam int PHASE_PAIRS   = 150;
    localparam int LONG_HOLD     = 100;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_ZERO = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [SW-1:0] i_x_re;
    logic signed [SW-1:0] i_x_im;
    logic signed [SW-1:0] i_y_re;
    logic signed [SW-1:0] i_y_im;
    logic                 i_last_pair;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [AW-1:0] o_sum_re;
    logic signed [AW-1:0] o_sum_im;
    logic                 o_saturated;

    int fail_count;
    int sums_pending;
    int sums_checked;
    int sums_clipped;

    // Pacing knobs, changed per phase by the request process
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int pairs_sent       = 0;
    // The request side asks for a long result hold-off; the result side
    // serves it on its next turn and counts it done.
    int long_holds_asked = 0;
    int long_holds_done  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    complex_conj_dot_product_unit #(
        .SAMPLE_WIDTH(SW),
        .ACC_WIDTH   (AW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_re     (i_x_re),
        .i_x_im     (i_x_im),
        .i_y_re     (i_y_re),
        .i_y_im     (i_y_im),
        .i_last_pair(i_last_pair),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sum_re   (o_sum_re),
        .o_sum_im   (o_sum_im),
        .o_saturated(o_saturated)
    );

    dot_product_checker #(
        .SW(SW),
        .AW(AW)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_stall (o_stall),
        .i_x_re      (i_x_re),
        .i_x_im      (i_x_im),
        .i_y_re      (i_y_re),
        .i_y_im      (i_y_im),
        .i_last_pair (i_last_pair),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_sum_re    (o_sum_re),
        .i_sum_im    (o_sum_im),
        .i_saturated (o_saturated),
        .o_fail_count(fail_count),
        .o_pending   (sums_pending),
        .o_results   (sums_checked),
        .o_clipped   (sums_clipped)
    );

    // Idle gap before the next handshake: none unless a draw under idle_pct picks a random gap
    function automatic int draw_wait(input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            return $urandom_range(0, 18);
        end
        return 0;
    endfunction

    // Each phase picks flat-out, light or heavy idling at random
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 25;
            default: return 70;
        endcase
    endfunction

    // Full-scale and sign-boundary values show up often, the rest is uniform
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MIN;
            1: return S_MAX;
            2: return S_ZERO;
            3: return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    // Vector length: many short ones so results come often, a few long ones
    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0, 1, 2: return 1;
            8: return $urandom_range(9, 30);
            9: return $urandom_range(31, 64);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    // One request: optional idle gap, then hold until accepted
    task automatic send_pair(input logic [SW-1:0] xr, input logic [SW-1:0] xi,
                             input logic [SW-1:0] yr, input logic [SW-1:0] yi,
                             input logic last);
        int gap;
        gap = draw_wait(send_idle_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_x_re      <= xr;
        i_x_im      <= xi;
        i_y_re      <= yr;
        i_y_im      <= yi;
        i_last_pair <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        pairs_sent++;
    endtask

    task automatic send_random_vector(input int len);
        for (int k = 0; k < len; k++) begin
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                      k == len - 1);
        end
    endtask

    // Request side: directed cases, back-pressure, random phases
    initial begin
        int base;
        int waited;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_x_re      = '0;
        i_x_im      = '0;
        i_y_re      = '0;
        i_y_im      = '0;
        i_last_pair = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-pair vectors, mostly at the corners of the sample range
        send_idle_pct = 30;
        recv_idle_pct = 30;
        send_pair(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1);
        send_pair(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1);
        send_pair(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
        send_pair(S_MIN, S_MAX, S_MAX, S_MIN, 1'b1);
        send_pair(S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b1);
        send_pair('1, SW'(1), SW'(1), '1, 1'b1);
        send_pair(SW'('h5555), SW'('haaaa), SW'('haaaa), SW'('h5555), 1'b1);
        // short vectors, small mixed-sign values, then cancelling extremes
        send_pair(SW'(1), SW'(2), SW'(3), SW'(4), 1'b0);
        send_pair(SW'(-5), SW'(6), SW'(-7), SW'(8), 1'b0);
        send_pair(SW'(100), SW'(-200), SW'(300), SW'(-400), 1'b1);
        send_pair(S_MIN, S_ZERO, S_MIN, S_ZERO, 1'b0);
        send_pair(S_MAX, S_ZERO, S_MIN, S_ZERO, 1'b0);
        send_pair(S_ZERO, S_MIN, S_ZERO, S_MAX, 1'b0);
        send_pair(S_ZERO, S_MAX, S_ZERO, S_MAX, 1'b1);
        send_pair(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0);
        send_pair(S_MIN, S_MAX, S_MIN, S_MAX, 1'b1);

        // Back-pressure: result side holds off long while requests keep
        // coming in short vectors, so the block fills and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_holds_asked++;
        repeat (30) send_random_vector($urandom_range(1, 2));

        // Random phases with varied idling on both sides
        base = pairs_sent;
        while (pairs_sent - base < RANDOM_PAIRS) begin
            send_idle_pct = pick_idle_pct();
            recv_idle_pct = pick_idle_pct();
            base = base;
            for (int n = 0; n < PHASE_PAIRS && pairs_sent - base < RANDOM_PAIRS; ) begin
                n = n + 1;
                send_random_vector(pick_len());
            end
        end
        i_valid <= 1'b0;

        // Drain: every expected sum must arrive
        waited = 0;
        while (sums_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sums_pending != 0) begin
            $display("%0d sums never arrived", sums_pending);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            // settle first so a stray extra result gets caught
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            $display("Sent %0d sample pairs; checked %0d vector sums, %0d of them clipped",
                     pairs_sent, sums_checked, sums_clipped);
            $display("Covered corner samples, mixed-sign vectors and long output stalls");
            if (fail_count == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("%0d mismatches", fail_count);
                $display("CHECKS FAILED");
            end
            $finish;
        end
    end

    // Result side: random stall before each result, one long hold on request
    initial begin
        int gap;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(recv_idle_pct);
            if (long_holds_done < long_holds_asked) begin
                gap = LONG_HOLD;
                long_holds_done++;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (o_valid !== 1'b1);
        end
    end

    // Hang guard: well over the slowest legal run
    initial begin
        #10ms;
        $display("Timed out");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
design/ccdp_pkg.sv
design/ccdp_front.sv
design/ccdp_fifo.sv
design/ccdp_back.sv
design/complex_conj_dot_product_unit.sv
verif/dot_product_checker.sv
verif/testbench.sv
